/* sv/trd_pkg.sv */
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants for the touch report decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int BYTE_W     = 8;
    localparam int COORD_W    = 12;
    localparam int IDX_W      = 3;
    localparam int POS_W      = 5;
    localparam int ROT_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int NIB_W      = 4;

    localparam logic [IDX_W-1:0]  MAX_POINTS  = 3'd5;
    localparam logic [POS_W-1:0]  REPORT_LEN  = 5'd27;
    localparam logic [POS_W-1:0]  FILLER_END  = 5'd8;
    localparam logic [POS_W-1:0]  FIRST_LEN   = 5'd5;
    localparam logic [NIB_W-1:0]  ID_CODE     = 4'h6;
    localparam int                QUEUE_DEPTH = 2;

    localparam logic [COORD_W-1:0] PANEL_W_RST = 12'd320;
    localparam logic [COORD_W-1:0] PANEL_H_RST = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATION     = 2'd0,
        CFG_PANEL_WIDTH  = 2'd1,
        CFG_PANEL_HEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [ROT_W-1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    // one decoded result waiting for the back end
    typedef struct packed {
        logic [IDX_W-1:0]   point_index;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [BYTE_W-1:0]  pressure;
        logic [IDX_W-1:0]   point_count;
        logic               has_point;
        logic               last;
    } trd_entry_t;

    // queue handshake between the front end and the queue
    typedef struct packed {
        logic       push;
        trd_entry_t entry;
    } trd_push_t;

endpackage

/* sv/trd_if.sv */
// ----------------------------------------------------------------------------
// trd_if
// Channel interfaces: report bytes in, decoded points out, register writes.
// ----------------------------------------------------------------------------
interface trd_in_if import trd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] report_byte;
    logic              frame_start;

    modport source (output valid, report_byte, frame_start, input ready);
    modport sink   (input valid, report_byte, frame_start, output ready);
endinterface

interface trd_out_if import trd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   point_index;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [BYTE_W-1:0]  pressure;
    logic [IDX_W-1:0]   point_count;
    logic               has_point;
    logic               last;

    modport source (output valid, point_index, coord_x, coord_y, pressure,
                    point_count, has_point, last, input ready);
    modport sink   (input valid, point_index, coord_x, coord_y, pressure,
                    point_count, has_point, last, output ready);
endinterface

interface trd_cfg_if import trd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/touch_report_decoder_rotate.sv */
// ----------------------------------------------------------------------------
// touch_report_decoder_rotate
// Decodes touch reports byte by byte and gives rotated touch points.
//
//   channel  dir  carries
//   rpt      in   report_byte, frame_start
//   pts      out  point_index, coord_x, coord_y, pressure, point_count,
//                 has_point, last
//   cfg      in   index, data (rotation, panel_width, panel_height)
//
// One byte per cycle while the queue is not full. A result passes from the
// parser through the two-entry queue, then the rotation stage into the output register.
// rpt stalls only when the queue is full; cfg is always ready.
// Reset clears parser state and loads rotation 0, panel 320 x 480.
// ----------------------------------------------------------------------------
module touch_report_decoder_rotate import trd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    trd_in_if.sink    rpt,
    trd_out_if.source pts,
    trd_cfg_if.sink   cfg
);

    trd_push_t  q_push;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    trd_entry_t q_head;

    trd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rpt    (rpt),
        .q_full (q_full),
        .q_push (q_push)
    );

    trd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    trd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pts     (pts)
    );

endmodule

/* sv/trd_front.sv */
// ----------------------------------------------------------------------------
// trd_front
// Byte parser: tracks report position, gathers point bytes, queues results.
// ----------------------------------------------------------------------------
module trd_front import trd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    trd_in_if.sink    rpt,
    input  logic      q_full,
    output trd_push_t q_push
);

    logic [POS_W-1:0]  byte_pos_reg, byte_pos_next;
    logic [IDX_W-1:0]  active_cnt_reg, active_cnt_next;
    logic              frame_active_reg, frame_active_next;
    logic [BYTE_W-1:0] x_hi_reg, x_hi_next;
    logic [BYTE_W-1:0] y_hi_reg, y_hi_next;
    logic [BYTE_W-1:0] lo_nib_reg, lo_nib_next;

    logic              accept;
    logic [NIB_W-1:0]  nib;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  q;
    logic [IDX_W-1:0]  pt;
    logic [POS_W-1:0]  off;
    logic              data_byte;
    logic [IDX_W-1:0]  cnt_clamp;
    trd_push_t         push_c;

    assign rpt.ready = !q_full;
    assign accept    = rpt.valid && rpt.ready;
    assign nib       = rpt.report_byte[NIB_W-1:0];
    assign pos_inc   = byte_pos_reg + POS_W'(1);
    assign cnt_clamp = (nib > NIB_W'(MAX_POINTS)) ? MAX_POINTS : IDX_W'(nib);

    // point and offset within the report
    always_comb
    begin
        q         = pos_inc - FILLER_END;
        data_byte = 1'b1;
        pt        = '0;
        off       = '0;
        if (pos_inc <= FIRST_LEN)
        begin
            off = pos_inc - POS_W'(1);
        end
        else if (pos_inc < FILLER_END)
        begin
            data_byte = 1'b0;
        end
        else if (q < POS_W'(5))
        begin
            pt  = IDX_W'(1);
            off = q;
        end
        else if (q < POS_W'(10))
        begin
            pt  = IDX_W'(2);
            off = q - POS_W'(5);
        end
        else if (q < POS_W'(15))
        begin
            pt  = IDX_W'(3);
            off = q - POS_W'(10);
        end
        else
        begin
            pt  = IDX_W'(4);
            off = q - POS_W'(15);
        end
    end

    always_comb
    begin
        byte_pos_next     = byte_pos_reg;
        active_cnt_next   = active_cnt_reg;
        frame_active_next = frame_active_reg;
        x_hi_next         = x_hi_reg;
        y_hi_next         = y_hi_reg;
        lo_nib_next       = lo_nib_reg;
        push_c            = '0;
        push_c.entry.last = 1'b1;

        if (accept)
        begin
            if (rpt.frame_start)
            begin
                frame_active_next = 1'b0;
                byte_pos_next     = '0;
                if (nib == '0)
                begin
                    active_cnt_next = '0;
                    push_c.push     = 1'b1;
                end
                else
                begin
                    active_cnt_next   = cnt_clamp;
                    frame_active_next = 1'b1;
                end
            end
            else if (frame_active_reg)
            begin
                if (pos_inc > REPORT_LEN)
                begin
                    frame_active_next = 1'b0;
                end
                else
                begin
                    byte_pos_next = pos_inc;
                    if (pos_inc == POS_W'(1))
                    begin
                        if (nib != ID_CODE)
                        begin
                            frame_active_next = 1'b0;
                            active_cnt_next   = '0;
                            push_c.push       = 1'b1;
                        end
                    end
                    else if (data_byte && (pt < active_cnt_reg))
                    begin
                        case (off)
                            POS_W'(1): x_hi_next   = rpt.report_byte;
                            POS_W'(2): y_hi_next   = rpt.report_byte;
                            POS_W'(3): lo_nib_next = rpt.report_byte;
                            POS_W'(4):
                            begin
                                push_c.push              = 1'b1;
                                push_c.entry.point_index = pt;
                                push_c.entry.x           = {x_hi_reg,
                                                            lo_nib_reg[7:4]};
                                push_c.entry.y           = {y_hi_reg,
                                                            lo_nib_reg[3:0]};
                                push_c.entry.pressure    = rpt.report_byte;
                                push_c.entry.point_count = active_cnt_reg;
                                push_c.entry.has_point   = 1'b1;
                                push_c.entry.last        =
                                    (pt + IDX_W'(1)) == active_cnt_reg;
                                if (push_c.entry.last)
                                begin
                                    frame_active_next = 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
    end

    assign q_push = push_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg     <= '0;
            active_cnt_reg   <= '0;
            frame_active_reg <= 1'b0;
            x_hi_reg         <= '0;
            y_hi_reg         <= '0;
            lo_nib_reg       <= '0;
        end
        else
        begin
            byte_pos_reg     <= byte_pos_next;
            active_cnt_reg   <= active_cnt_next;
            frame_active_reg <= frame_active_next;
            x_hi_reg         <= x_hi_next;
            y_hi_reg         <= y_hi_next;
            lo_nib_reg       <= lo_nib_next;
        end
    end

endmodule

/* sv/trd_queue.sv */
// ----------------------------------------------------------------------------
// trd_queue
// Small result queue between parser and coordinate stage.
// ----------------------------------------------------------------------------
module trd_queue import trd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  trd_push_t  q_push,
    output logic       q_full,
    output logic       q_valid,
    output trd_entry_t q_head,
    input  logic       q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    trd_entry_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign q_full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_head  = mem_reg[rd_ptr_reg];
    assign do_push = q_push.push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* sv/trd_back.sv */
// ----------------------------------------------------------------------------
// trd_back
// Config registers, coordinate rotation and output register.
// ----------------------------------------------------------------------------
module trd_back import trd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    trd_cfg_if.sink    cfg,
    input  logic       q_valid,
    input  trd_entry_t q_head,
    output logic       q_pop,
    trd_out_if.source  pts
);

    function automatic logic [COORD_W-1:0] sat_sub(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        sat_sub = (a > b) ? (a - b) : '0;
    endfunction

    rot_t               rot_reg;
    logic [COORD_W-1:0] panel_w_reg;
    logic [COORD_W-1:0] panel_h_reg;

    logic               out_valid_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [COORD_W-1:0] cx_reg, cx_next;
    logic [COORD_W-1:0] cy_reg, cy_next;
    logic [BYTE_W-1:0]  pres_reg;
    logic [IDX_W-1:0]   cnt_reg;
    logic               has_reg;
    logic               last_reg;

    logic [COORD_W-1:0] side_lo;
    logic [COORD_W-1:0] side_hi;
    logic [COORD_W-1:0] w_m1;
    logic [COORD_W-1:0] h_m1;
    logic               cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg     <= ROT_0;
            panel_w_reg <= PANEL_W_RST;
            panel_h_reg <= PANEL_H_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg.index)
                CFG_ROTATION:     rot_reg     <= rot_t'(cfg.data[ROT_W-1:0]);
                CFG_PANEL_WIDTH:  panel_w_reg <= cfg.data;
                CFG_PANEL_HEIGHT: panel_h_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign side_lo = (panel_w_reg < panel_h_reg) ? panel_w_reg : panel_h_reg;
    assign side_hi = (panel_w_reg < panel_h_reg) ? panel_h_reg : panel_w_reg;

    always_comb
    begin
        if (rot_reg == ROT_90 || rot_reg == ROT_270)
        begin
            w_m1 = sat_sub(side_hi, COORD_W'(1));
            h_m1 = sat_sub(side_lo, COORD_W'(1));
        end
        else
        begin
            w_m1 = sat_sub(side_lo, COORD_W'(1));
            h_m1 = sat_sub(side_hi, COORD_W'(1));
        end

        unique case (rot_reg)
            ROT_90:
            begin
                cx_next = q_head.y;
                cy_next = sat_sub(h_m1, q_head.x);
            end
            ROT_180:
            begin
                cx_next = sat_sub(w_m1, q_head.x);
                cy_next = sat_sub(h_m1, q_head.y);
            end
            ROT_270:
            begin
                cx_next = sat_sub(w_m1, q_head.y);
                cy_next = q_head.x;
            end
            default:
            begin
                cx_next = q_head.x;
                cy_next = q_head.y;
            end
        endcase

        if (!q_head.has_point)
        begin
            cx_next = '0;
            cy_next = '0;
        end
    end

    assign q_pop = q_valid && (!out_valid_reg || pts.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pts.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            idx_reg  <= q_head.point_index;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            pres_reg <= q_head.pressure;
            cnt_reg  <= q_head.point_count;
            has_reg  <= q_head.has_point;
            last_reg <= q_head.last;
        end
    end

    assign pts.valid       = out_valid_reg;
    assign pts.point_index = idx_reg;
    assign pts.coord_x     = cx_reg;
    assign pts.coord_y     = cy_reg;
    assign pts.pressure    = pres_reg;
    assign pts.point_count = cnt_reg;
    assign pts.has_point   = has_reg;
    assign pts.last        = last_reg;

endmodule
